// ===== hw/rtl/acs_pkg.sv =====
// Shared types and constants of the all-to-all collective sequencer.
// Used by every module of the block; depends on nothing.
package acs_pkg;

  localparam int RANK_W   = 11;  // rank count and effective rank count
  localparam int RID_W    = 10;  // rank identifier and destination
  localparam int BLEN_W   = 16;  // elements per block
  localparam int RPS_W    = 8;   // receive counter width
  localparam int LEN_W    = 26;  // send length
  localparam int FACTOR_W = 11;  // block multiplier factor
  localparam int NUM_W    = 12;  // numerator of the destination modulo
  localparam int CFG_W    = 16;  // configuration write data

  localparam logic [RANK_W-1:0] MAX_RANKS = 11'd1024;

  typedef enum logic [2:0] {
    OP_START     = 3'd0,
    OP_COPY_DONE = 3'd1,
    OP_INITIAL   = 3'd2,
    OP_LAST      = 3'd3,
    OP_WHOLE     = 3'd4,
    OP_SEND_DONE = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ACT_COPY     = 2'd0,
    ACT_SEND     = 2'd1,
    ACT_FINISHED = 2'd2,
    ACT_INVALID  = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    KIND_INITIAL = 2'd0,
    KIND_LAST    = 2'd1,
    KIND_WHOLE   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_RANK_COUNT    = 2'd0,
    CFG_OWN_RANK      = 2'd1,
    CFG_BLOCK_LEN     = 2'd2,
    CFG_RECV_PER_STEP = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    PH_START = 1'b0,
    PH_WAIT  = 1'b1
  } phase_e;

  // What the captured event asks for
  typedef enum logic [1:0] {
    DEC_INVALID,
    DEC_START,
    DEC_NONE,
    DEC_ROUND
  } dec_e;

  // What the next round does
  typedef enum logic [1:0] {
    RND_STEP,
    RND_REMAINDER,
    RND_FINISH
  } rnd_e;

  // Which result the datapath pushes
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_INVALID,
    EMIT_COPY,
    EMIT_FINISH,
    EMIT_SEND
  } emit_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_ROUND,
    ST_MUL_A,
    ST_MUL_B,
    ST_MOD,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic  capture;
    logic  apply;
    logic  round;
    logic  mul_a;
    logic  mul_b;
    emit_e emit;
  } cmd_t;

  typedef struct packed {
    dec_e dec;
    rnd_e rnd;
    logic mod_busy;
  } sts_t;

  typedef struct packed {
    act_e             action;
    logic [RID_W-1:0] dest_rank;
    logic [LEN_W-1:0] length;
    kind_e            piece_kind;
    logic [1:0]       msg_epoch;
    logic             wants_completion;
    logic             last;
  } res_t;

endpackage

// ===== hw/rtl/acs_mod.sv =====
// Iterative remainder unit: numerator modulo divisor, one bit per cycle.
// Depends on acs_pkg for the operand widths.
module acs_mod
  import acs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NUM_W-1:0]    num_i,
  input  logic [RANK_W-1:0]   div_i,
  output logic                busy_o,
  output logic [RID_W-1:0]    rem_o
);

  localparam int CntW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  num_q, num_d;
  logic [NUM_W-1:0]  rem_q, rem_d;
  logic [RANK_W-1:0] div_q, div_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic [NUM_W-1:0]  trial;

  assign trial = {rem_q[NUM_W-2:0], num_q[NUM_W-1]};

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      div_d  = div_i;
      cnt_d  = CntW'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in the next numerator bit, subtract when it fits
      if (trial >= {1'b0, div_q}) begin
        rem_d = trial - {1'b0, div_q};
      end else begin
        rem_d = trial;
      end
      num_d = {num_q[NUM_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q[RID_W-1:0];

endmodule

// ===== hw/rtl/acs_dpath.sv =====
// Datapath: configuration, sequencer state, step operands, length products
// and result formatting. Depends on acs_pkg and acs_mod.
module acs_dpath
  import acs_pkg::*;
#(
  parameter int unsigned EPOCH_COUNT = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  logic [2:0]         op_i,
  input  logic [1:0]         tag_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic               push_o,
  output logic               push_two_o,
  output res_t               res_a_o,
  output res_t               res_b_o
);

  localparam int EpochW = $clog2(EPOCH_COUNT);

  // configuration
  logic [RANK_W-1:0] rank_count_q;
  logic [RID_W-1:0]  own_rank_q;
  logic [BLEN_W-1:0] block_len_q;
  logic [RPS_W-1:0]  rps_q;

  // sequencer state
  phase_e             phase_q, phase_d;
  logic [RID_W-1:0]   steps_left_q, steps_left_d;
  logic [RANK_W-1:0]  stride_q, stride_d;
  logic [EpochW-1:0]  epoch_q, epoch_d;
  logic               rem_done_q, rem_done_d;
  logic [RPS_W-1:0]   cnt_q [EPOCH_COUNT];
  logic [RPS_W-1:0]   cnt_d [EPOCH_COUNT];
  logic [1:0]         sends_cmp_q, sends_cmp_d;
  logic [1:0]         sends_exp_q, sends_exp_d;
  logic               sends_done_q, sends_done_d;
  logic               recv_done_q, recv_done_d;

  // captured event and step operands
  logic [2:0]          op_q;
  logic [1:0]          tag_q;
  logic [FACTOR_W-1:0] fa_q, fb_q;
  logic                split_q, is_rem_q;
  logic [LEN_W-1:0]    len_a_q, len_b_q;

  // derived values
  logic [RANK_W-1:0]   n_eff, low_pow, extra, r_ext, r_plus1;
  logic                non_pow2;
  logic [NUM_W-1:0]    sum_step, sum_rem, mod_num;
  logic                split_step, split_rem;
  logic [FACTOR_W-1:0] fa_step, fa_rem;
  logic [4:0]          tag_w, tag_mod;
  logic [RPS_W-1:0]    cnt_inc [EPOCH_COUNT];
  logic [EPOCH_COUNT-1:0] ev_hit, cm_hit;
  logic                recv_ev, recv_cm;
  logic                is_data, is_sdone;
  logic [1:0]          cmp_inc;
  logic                send_match, sdone_n, rdone_n, advance;
  dec_e                dec;
  rnd_e                rnd;
  logic                mod_busy;
  logic [RID_W-1:0]    mod_rem;
  logic [FACTOR_W-1:0] mul_op;
  logic [LEN_W:0]      mul_prod;
  logic [1:0]          ep_out;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_count_q <= RANK_W'(2);
      own_rank_q   <= '0;
      block_len_q  <= BLEN_W'(1);
      rps_q        <= RPS_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_RANK_COUNT:    rank_count_q <= cfg_wdata_i[RANK_W-1:0];
        CFG_OWN_RANK:      own_rank_q   <= cfg_wdata_i[RID_W-1:0];
        CFG_BLOCK_LEN:     block_len_q  <= cfg_wdata_i[BLEN_W-1:0];
        CFG_RECV_PER_STEP: rps_q        <= cfg_wdata_i[RPS_W-1:0];
        default:           rps_q        <= rps_q;
      endcase
    end
  end

  // effective rank count, its largest power of two and the surplus
  always_comb begin
    if (rank_count_q == '0) begin
      n_eff = RANK_W'(1);
    end else if (rank_count_q > MAX_RANKS) begin
      n_eff = MAX_RANKS;
    end else begin
      n_eff = rank_count_q;
    end
    low_pow = '0;
    for (int i = 0; i < RANK_W; i++) begin
      if (n_eff[i]) begin
        low_pow = RANK_W'(1) << i;
      end
    end
  end

  assign non_pow2 = |(n_eff & (n_eff - RANK_W'(1)));
  assign extra    = n_eff - low_pow;
  assign r_ext    = {1'b0, own_rank_q};
  assign r_plus1  = r_ext + RANK_W'(1);

  assign sum_step   = {1'b0, r_ext} + {1'b0, stride_q};
  assign split_step = (block_len_q != '0) && (r_plus1 < stride_q);
  assign fa_step    = split_step ? (stride_q - r_plus1) : stride_q;

  // destination of the remainder step is own + n - extra, i.e. own + low_pow
  assign sum_rem   = {1'b0, r_ext} + {1'b0, low_pow};
  assign split_rem = r_plus1 < extra;
  assign fa_rem    = split_rem ? (extra - r_plus1) : extra;

  always_comb begin
    if (steps_left_q != '0) begin
      rnd = RND_STEP;
    end else if (!rem_done_q && non_pow2) begin
      rnd = RND_REMAINDER;
    end else begin
      rnd = RND_FINISH;
    end
  end

  // receive counters: each entry checks itself against the current epoch
  assign tag_w   = {3'b000, tag_q};
  assign tag_mod = (tag_w >= 5'(EPOCH_COUNT)) ? (tag_w - 5'(EPOCH_COUNT)) : tag_w;

  always_comb begin
    for (int i = 0; i < EPOCH_COUNT; i++) begin
      cnt_inc[i] = cnt_q[i] + RPS_W'(tag_mod == 5'(i));
      ev_hit[i]  = (epoch_q == EpochW'(i)) && (cnt_inc[i] == rps_q);
      cm_hit[i]  = (epoch_q == EpochW'(i)) && (cnt_q[i] == rps_q);
    end
  end

  assign recv_ev = |ev_hit;
  assign recv_cm = |cm_hit;

  // event decode
  assign is_data    = (op_q == OP_LAST) || (op_q == OP_WHOLE);
  assign is_sdone   = (op_q == OP_SEND_DONE) && (phase_q == PH_WAIT);
  assign cmp_inc    = sends_cmp_q + 2'd1;
  assign send_match = cmp_inc == sends_exp_q;
  assign sdone_n    = sends_done_q | (is_sdone && send_match);
  assign rdone_n    = recv_done_q | (is_data && recv_ev);
  assign advance    = sdone_n && rdone_n;

  always_comb begin
    dec = DEC_INVALID;
    if (phase_q == PH_START) begin
      unique case (op_q) inside
        OP_START:          dec = DEC_START;
        OP_COPY_DONE:      dec = DEC_ROUND;
        OP_INITIAL:        dec = DEC_NONE;
        OP_LAST, OP_WHOLE: dec = DEC_NONE;
        default:           dec = DEC_INVALID;
      endcase
    end else begin
      unique case (op_q) inside
        OP_SEND_DONE, OP_LAST, OP_WHOLE: dec = advance ? DEC_ROUND : DEC_NONE;
        OP_INITIAL:                      dec = DEC_NONE;
        default:                         dec = DEC_INVALID;
      endcase
    end
  end

  // state update
  always_comb begin
    phase_d      = phase_q;
    steps_left_d = steps_left_q;
    stride_d     = stride_q;
    epoch_d      = epoch_q;
    rem_done_d   = rem_done_q;
    cnt_d        = cnt_q;
    sends_cmp_d  = sends_cmp_q;
    sends_exp_d  = sends_exp_q;
    sends_done_d = sends_done_q;
    recv_done_d  = recv_done_q;

    if (cmd_i.apply) begin
      if (dec == DEC_START) begin
        steps_left_d = n_eff[RANK_W-1:1];
        stride_d     = RANK_W'(1);
        rem_done_d   = 1'b0;
        epoch_d      = '0;
      end else if (dec != DEC_INVALID) begin
        if (is_data) begin
          for (int i = 0; i < EPOCH_COUNT; i++) begin
            cnt_d[i] = ev_hit[i] ? '0 : cnt_inc[i];
          end
        end
        if (is_sdone) begin
          if (send_match) begin
            sends_cmp_d = '0;
            sends_exp_d = '0;
          end else begin
            sends_cmp_d = cmp_inc;
          end
        end
        if (phase_q == PH_WAIT && dec == DEC_ROUND) begin
          sends_done_d = 1'b0;
          recv_done_d  = 1'b0;
        end else begin
          sends_done_d = sdone_n;
          recv_done_d  = rdone_n;
        end
      end
    end

    if (cmd_i.round) begin
      epoch_d = (epoch_q == EpochW'(EPOCH_COUNT - 1)) ? '0 : epoch_q + EpochW'(1);
      if (rnd == RND_FINISH) begin
        phase_d = PH_START;
      end
    end

    // close a step once its sends are issued
    if (cmd_i.emit == EMIT_SEND) begin
      sends_exp_d  = sends_exp_q + 2'd1;
      stride_d     = {stride_q[RANK_W-2:0], 1'b0};
      steps_left_d = steps_left_q >> 1;
      phase_d      = PH_WAIT;
      if (is_rem_q) begin
        rem_done_d = 1'b1;
      end
      for (int i = 0; i < EPOCH_COUNT; i++) begin
        if (cm_hit[i]) begin
          cnt_d[i] = '0;
        end
      end
      recv_done_d = recv_done_q | recv_cm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_START;
      steps_left_q <= '0;
      stride_q     <= RANK_W'(1);
      epoch_q      <= '0;
      rem_done_q   <= 1'b0;
      for (int i = 0; i < EPOCH_COUNT; i++) begin
        cnt_q[i] <= '0;
      end
      sends_cmp_q  <= '0;
      sends_exp_q  <= '0;
      sends_done_q <= 1'b0;
      recv_done_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      steps_left_q <= steps_left_d;
      stride_q     <= stride_d;
      epoch_q      <= epoch_d;
      rem_done_q   <= rem_done_d;
      cnt_q        <= cnt_d;
      sends_cmp_q  <= sends_cmp_d;
      sends_exp_q  <= sends_exp_d;
      sends_done_q <= sends_done_d;
      recv_done_q  <= recv_done_d;
    end
  end

  // captured event, step operands and products
  assign mul_op   = cmd_i.mul_b ? fb_q : fa_q;
  assign mul_prod = (LEN_W + 1)'(mul_op) * (LEN_W + 1)'(block_len_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_i;
      tag_q <= tag_i;
    end
    if (cmd_i.round) begin
      fb_q     <= r_plus1;
      is_rem_q <= rnd == RND_REMAINDER;
      if (rnd == RND_REMAINDER) begin
        fa_q    <= fa_rem;
        split_q <= split_rem;
      end else begin
        fa_q    <= fa_step;
        split_q <= split_step;
      end
    end
    if (cmd_i.mul_a) begin
      len_a_q <= mul_prod[LEN_W-1:0];
    end
    if (cmd_i.mul_b) begin
      len_b_q <= mul_prod[LEN_W-1:0];
    end
  end

  assign mod_num = (rnd == RND_REMAINDER) ? sum_rem : sum_step;

  acs_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.round && (rnd != RND_FINISH)),
    .num_i   (mod_num),
    .div_i   (n_eff),
    .busy_o  (mod_busy),
    .rem_o   (mod_rem)
  );

  // result formatting
  assign ep_out = 2'(epoch_q);

  always_comb begin
    res_a_o = '0;
    res_b_o = '0;
    res_a_o.last = 1'b1;
    unique case (cmd_i.emit)
      EMIT_INVALID: res_a_o.action = ACT_INVALID;
      EMIT_COPY: begin
        res_a_o.action = ACT_COPY;
        res_a_o.length = LEN_W'(block_len_q);
      end
      EMIT_FINISH: res_a_o.action = ACT_FINISHED;
      EMIT_SEND: begin
        res_a_o.action    = ACT_SEND;
        res_a_o.dest_rank = mod_rem;
        res_a_o.length    = len_a_q;
        res_a_o.msg_epoch = ep_out;
        if (split_q) begin
          res_a_o.piece_kind       = KIND_INITIAL;
          res_a_o.wants_completion = 1'b0;
          res_a_o.last             = 1'b0;
          res_b_o.action           = ACT_SEND;
          res_b_o.dest_rank        = mod_rem;
          res_b_o.length           = len_b_q;
          res_b_o.piece_kind       = KIND_LAST;
          res_b_o.msg_epoch        = ep_out;
          res_b_o.wants_completion = 1'b1;
          res_b_o.last             = 1'b1;
        end else begin
          res_a_o.piece_kind       = KIND_WHOLE;
          res_a_o.wants_completion = 1'b1;
        end
      end
      default: res_a_o.last = 1'b1;
    endcase
  end

  assign push_o     = cmd_i.emit != EMIT_NONE;
  assign push_two_o = (cmd_i.emit == EMIT_SEND) && split_q;

  assign sts_o.dec      = dec;
  assign sts_o.rnd      = rnd;
  assign sts_o.mod_busy = mod_busy;

endmodule

// ===== hw/rtl/acs_outbuf.sv =====
// Two-entry result queue between the datapath and the output stream.
// Depends on acs_pkg for the result record.
module acs_outbuf
  import acs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  logic push_two_i,
  input  res_t res_a_i,
  input  res_t res_b_i,
  input  logic pop_i,
  output logic empty_o,
  output logic valid_o,
  output res_t head_o
);

  logic [1:0] count_q, count_d;
  res_t       slot0_q, slot1_q;

  // pushes only arrive while the queue is empty
  always_comb begin
    count_d = count_q;
    if (push_i) begin
      count_d = push_two_i ? 2'd2 : 2'd1;
    end else if (pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot0_q <= res_a_i;
      slot1_q <= res_b_i;
    end else if (pop_i) begin
      slot0_q <= slot1_q;
    end
  end

  assign empty_o = count_q == 2'd0;
  assign valid_o = count_q != 2'd0;
  assign head_o  = slot0_q;

endmodule

// ===== hw/rtl/acs_ctrl.sv =====
// Controller state machine: sequences capture, event update, round setup,
// length products, destination modulo and result push. Depends on acs_pkg.
module acs_ctrl
  import acs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  input  logic out_empty_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        unique case (sts_i.dec)
          DEC_NONE:  state_d = ST_IDLE;
          DEC_ROUND: state_d = ST_ROUND;
          default: begin
            if (out_empty_i) state_d = ST_IDLE;
          end
        endcase
      end
      ST_ROUND: begin
        if (sts_i.rnd != RND_FINISH) begin
          state_d = ST_MUL_A;
        end else if (out_empty_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_MUL_A: state_d = ST_MUL_B;
      ST_MUL_B: state_d = ST_MOD;
      ST_MOD: begin
        if (!sts_i.mod_busy) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_empty_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.emit    = EMIT_NONE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EVAL: begin
        unique case (sts_i.dec)
          DEC_INVALID: begin
            if (out_empty_i) cmd_o.emit = EMIT_INVALID;
          end
          DEC_START: begin
            if (out_empty_i) begin
              cmd_o.apply = 1'b1;
              cmd_o.emit  = EMIT_COPY;
            end
          end
          default: cmd_o.apply = 1'b1;
        endcase
      end
      ST_ROUND: begin
        if (sts_i.rnd != RND_FINISH) begin
          cmd_o.round = 1'b1;
        end else if (out_empty_i) begin
          cmd_o.round = 1'b1;
          cmd_o.emit  = EMIT_FINISH;
        end
      end
      ST_MUL_A: cmd_o.mul_a = 1'b1;
      ST_MUL_B: cmd_o.mul_b = 1'b1;
      ST_MOD:   cmd_o.apply = 1'b0;
      ST_EMIT: begin
        if (out_empty_i) cmd_o.emit = EMIT_SEND;
      end
      default: cmd_o.apply = 1'b0;
    endcase
  end

endmodule

// ===== hw/rtl/alltoall_collective_sequencer_unit.sv =====
// Top level of the all-to-all collective sequencer for one rank.
// Depends on acs_pkg, acs_ctrl, acs_dpath (with acs_mod) and acs_outbuf.
//
//  channel   direction  transfer when          payload
//  s_axis    in         tvalid & tready        tuser: operation, tdata: event epoch
//  m_axis    out        tvalid & tready        tuser: action, piece kind;
//                                              tdata: dest, length, epoch, wants; tlast
//  cfg       in         cfg_we_i               cfg_addr_i selects, cfg_wdata_i value
//
// Sequencing: one item is worked at a time. An event that gives no result or a
// single invalid or copy result passes transfer and decode; one that ends the
// exchange with a finished result passes transfer, decode and round. An event
// that opens a step also waits on the twelve iterations of the shared remainder
// unit that computes the destination rank.
// Reset: all control state and the configuration registers take their reset
// values at once; there is no clearing pass.
// Stalls: results wait in a two-entry queue, so the next input is taken while
// they drain; a later result is held back until the queue is empty.
module alltoall_collective_sequencer_unit
  import acs_pkg::*;
#(
  parameter int unsigned EPOCH_COUNT = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration writes
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_addr_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  // event stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [1:0] event_epoch, rest zero
  input  logic [2:0]       s_axis_tuser,   // [2:0] operation
  // result stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [9:0] dest_rank, [35:10] length,
                                           // [37:36] msg_epoch, [38] wants_completion
  output logic [3:0]       m_axis_tuser,   // [1:0] action, [3:2] piece_kind
  output logic             m_axis_tlast
);

  cmd_t cmd;
  sts_t sts;
  logic push, push_two, out_empty, out_valid;
  res_t res_a, res_b, head;

  // sequence each accepted event
  acs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .sts_i       (sts),
    .out_empty_i (out_empty),
    .cmd_o       (cmd)
  );

  // hold configuration and exchange state, build results
  acs_dpath #(
    .EPOCH_COUNT (EPOCH_COUNT)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (s_axis_tuser),
    .tag_i       (s_axis_tdata[1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .push_o      (push),
    .push_two_o  (push_two),
    .res_a_o     (res_a),
    .res_b_o     (res_b)
  );

  // decouple the result stream from the sequencer
  acs_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_two_i (push_two),
    .res_a_i    (res_a),
    .res_b_i    (res_b),
    .pop_i      (out_valid && m_axis_tready),
    .empty_o    (out_empty),
    .valid_o    (out_valid),
    .head_o     (head)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, head.wants_completion, head.msg_epoch, head.length,
                          head.dest_rank};
  assign m_axis_tuser  = {head.piece_kind, head.action};
  assign m_axis_tlast  = head.last;

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for alltoall_collective_sequencer_unit.
// Drives event transfers, predicts the command stream in place and checks it.
// Depends on acs_pkg and the sequencer RTL only.
module tb;
  import acs_pkg::*;

  // Reserved operation codes; the block must reject both
  localparam logic [2:0] OP_RESERVED_LO = 3'd6;
  localparam logic [2:0] OP_RESERVED_HI = 3'd7;

  localparam int RANDOM_EVENTS = 1100;
  localparam int SETTLE_CYCLES = 32;    // outlasts the longest event, one that opens a step
  localparam int STALL_LIMIT   = 3000;  // cycles without any transfer

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] epoch;
  } ev_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [1:0]       cfg_addr_i = CFG_RANK_COUNT;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = '0;   // [1:0] event_epoch, rest zero
  logic [2:0]       s_axis_tuser = '0;   // [2:0] operation
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [39:0]      m_axis_tdata;        // [9:0] dest_rank, [35:10] length,
                                         // [37:36] msg_epoch, [38] wants_completion
  logic [3:0]       m_axis_tuser;        // [1:0] action, [3:2] piece_kind
  logic             m_axis_tlast;

  alltoall_collective_sequencer_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Event transfers waiting for the driver, and commands the sequencer still owes
  ev_t  pending_events[$];
  res_t due_commands[$];
  int   n_pushed = 0;
  int   n_taken = 0;
  int   src_idle_pct = 31;
  int   sink_idle_pct = 62;
  int   mismatches = 0;
  int   quiet_cycles = 0;
  ev_t  next_ev;
  res_t seen_cmd;
  res_t want_cmd;

  // ---------------------------------------------------------------------------
  // Sequencer shadow: configuration and control state as the block keeps them
  // ---------------------------------------------------------------------------
  logic [10:0] cfg_ranks = 11'd2;
  logic [9:0]  cfg_own = 10'd0;
  logic [15:0] cfg_blen = 16'd1;
  logic [7:0]  cfg_rps = 8'd1;

  phase_e      seq_phase = PH_START;
  logic [9:0]  steps_left = '0;
  logic [10:0] stride = 11'd1;
  logic [1:0]  epoch_now = '0;
  logic        rem_done = 1'b0;
  logic [7:0]  recv_counts [4] = '{default: 8'd0};
  logic [1:0]  sends_completed = '0;
  logic [1:0]  sends_expected = '0;
  logic        sends_all_done = 1'b0;
  logic        receives_all_done = 1'b0;

  // Rank count as the block uses it: zero acts as one, large values saturate
  function automatic logic [10:0] eff_ranks();
    if (cfg_ranks == 11'd0) return 11'd1;
    if (cfg_ranks > MAX_RANKS) return MAX_RANKS;
    return cfg_ranks;
  endfunction

  function automatic void queue_result(act_e a, logic [63:0] dest, logic [63:0] len,
                                       kind_e k, logic [1:0] ep, logic w, logic l);
    res_t r;
    r.action           = a;
    r.dest_rank        = dest[RID_W-1:0];
    r.length           = len[LEN_W-1:0];
    r.piece_kind       = k;
    r.msg_epoch        = ep;
    r.wants_completion = w;
    r.last             = l;
    due_commands.push_back(r);
  endfunction

  // Close the receive side once the current epoch has its quota of final pieces
  task automatic check_recv();
    if (recv_counts[epoch_now] == cfg_rps) begin
      recv_counts[epoch_now] = 8'd0;
      receives_all_done = 1'b1;
    end
  endtask

  task automatic count_piece(input logic [1:0] tag);
    recv_counts[tag] = recv_counts[tag] + 8'd1;
    check_recv();
  endtask

  // Issue one step: a whole send, or an initial and a last piece when the window wraps
  task automatic finish_step(input logic [63:0] dest, input logic [63:0] first,
                             input logic [63:0] second, input logic split);
    if (split) begin
      queue_result(ACT_SEND, dest, first, KIND_INITIAL, epoch_now, 1'b0, 1'b0);
      queue_result(ACT_SEND, dest, second, KIND_LAST, epoch_now, 1'b1, 1'b1);
    end else begin
      queue_result(ACT_SEND, dest, first, KIND_WHOLE, epoch_now, 1'b1, 1'b1);
    end
    sends_expected = sends_expected + 2'd1;
    stride = stride << 1;
    steps_left = steps_left >> 1;
    seq_phase = PH_WAIT;
    check_recv();
  endtask

  // Advance the epoch and run a regular step, the remainder step, or finish
  task automatic next_round();
    logic [63:0] n, r, len, s, low, extra;
    n = 64'(eff_ranks());
    r = 64'(cfg_own);
    len = 64'(cfg_blen);
    s = 64'(stride);
    epoch_now = epoch_now + 2'd1;
    if (steps_left != 10'd0) begin
      if (len != 64'd0 && r + 64'd1 < s)
        finish_step((r + s) % n, (s - 64'd1 - r) * len, (r + 64'd1) * len, 1'b1);
      else
        finish_step((r + s) % n, s * len, 64'd0, 1'b0);
    end else if (!rem_done && (n & (n - 64'd1)) != 64'd0) begin
      low = 64'd1;
      while ((low << 1) <= n) low = low << 1;
      extra = n - low;
      rem_done = 1'b1;
      if (r + 64'd1 < extra)
        finish_step((r + n - extra) % n, (extra - r - 64'd1) * len, (r + 64'd1) * len, 1'b1);
      else
        finish_step((r + n - extra) % n, extra * len, 64'd0, 1'b0);
    end else begin
      seq_phase = PH_START;
      queue_result(ACT_FINISHED, 64'd0, 64'd0, KIND_INITIAL, 2'd0, 1'b0, 1'b1);
    end
  endtask

  task automatic maybe_advance();
    if (sends_all_done && receives_all_done) begin
      sends_all_done = 1'b0;
      receives_all_done = 1'b0;
      next_round();
    end
  endtask

  // Work out the commands that one accepted event causes
  task automatic sequence_event(input logic [2:0] op, input logic [1:0] tag);
    logic [10:0] half;
    if (seq_phase == PH_START) begin
      case (op)
        OP_START: begin
          half = eff_ranks() >> 1;
          steps_left = half[9:0];
          stride = 11'd1;
          rem_done = 1'b0;
          epoch_now = 2'd0;
          queue_result(ACT_COPY, 64'd0, 64'(cfg_blen), KIND_INITIAL, 2'd0, 1'b0, 1'b1);
        end
        OP_COPY_DONE: next_round();
        OP_INITIAL: ;
        OP_LAST, OP_WHOLE: count_piece(tag);
        default: queue_result(ACT_INVALID, 64'd0, 64'd0, KIND_INITIAL, 2'd0, 1'b0, 1'b1);
      endcase
    end else begin
      case (op)
        OP_SEND_DONE: begin
          sends_completed = sends_completed + 2'd1;
          if (sends_completed == sends_expected) begin
            sends_expected = 2'd0;
            sends_completed = 2'd0;
            sends_all_done = 1'b1;
          end
          maybe_advance();
        end
        OP_LAST, OP_WHOLE: begin
          count_piece(tag);
          maybe_advance();
        end
        OP_INITIAL: ;
        default: queue_result(ACT_INVALID, 64'd0, 64'd0, KIND_INITIAL, 2'd0, 1'b0, 1'b1);
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued events; predict each one at its transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sequence_event(s_axis_tuser, s_axis_tdata[1:0]);
        n_taken++;
      end
      // Load the next event only when the slot is free; hold it otherwise
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_ev = pending_events.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= next_ev.op;
          s_axis_tdata  <= {6'd0, next_ev.epoch};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random backpressure, check every command transfer, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        seen_cmd.action           = act_e'(m_axis_tuser[1:0]);
        seen_cmd.piece_kind       = kind_e'(m_axis_tuser[3:2]);
        seen_cmd.dest_rank        = m_axis_tdata[9:0];
        seen_cmd.length           = m_axis_tdata[35:10];
        seen_cmd.msg_epoch        = m_axis_tdata[37:36];
        seen_cmd.wants_completion = m_axis_tdata[38];
        seen_cmd.last             = m_axis_tlast;
        if (due_commands.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected command: action %0d dest %0d length %0d kind %0d",
                     seen_cmd.action, seen_cmd.dest_rank, seen_cmd.length,
                     seen_cmd.piece_kind);
          mismatches++;
        end else begin
          want_cmd = due_commands.pop_front();
          if (seen_cmd.action !== want_cmd.action ||
              seen_cmd.dest_rank !== want_cmd.dest_rank ||
              seen_cmd.length !== want_cmd.length ||
              seen_cmd.piece_kind !== want_cmd.piece_kind ||
              seen_cmd.msg_epoch !== want_cmd.msg_epoch ||
              seen_cmd.wants_completion !== want_cmd.wants_completion ||
              seen_cmd.last !== want_cmd.last) begin
            if (mismatches < 10) begin
              $display("command mismatch at %0t", $realtime);
              $display("  expected: act %0d dest %0d len %0d kind %0d ep %0d wants %0b last %0b",
                       want_cmd.action, want_cmd.dest_rank, want_cmd.length,
                       want_cmd.piece_kind, want_cmd.msg_epoch,
                       want_cmd.wants_completion, want_cmd.last);
              $display("  actual:   act %0d dest %0d len %0d kind %0d ep %0d wants %0b last %0b",
                       seen_cmd.action, seen_cmd.dest_rank, seen_cmd.length,
                       seen_cmd.piece_kind, seen_cmd.msg_epoch,
                       seen_cmd.wants_completion, seen_cmd.last);
            end
            mismatches++;
          end
        end
      end
      // Any transfer or register write counts as progress
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        quiet_cycles = 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic ev_t make_ev(logic [2:0] op, logic [1:0] tag);
    ev_t e;
    e.op = op;
    e.epoch = tag;
    return e;
  endfunction

  function automatic ev_t random_event();
    return make_ev(3'($urandom_range(7)), 2'($urandom_range(3)));
  endfunction

  function automatic void add_event(ev_t e);
    pending_events.push_back(e);
    n_pushed++;
  endfunction

  // Wait until every queued event has been transferred and predicted
  task automatic wait_drained();
    while (n_taken != n_pushed) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    wait_drained();
    while (due_commands.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e addr, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= val;
    case (addr)
      CFG_RANK_COUNT:    cfg_ranks = val[10:0];
      CFG_OWN_RANK:      cfg_own   = val[9:0];
      CFG_BLOCK_LEN:     cfg_blen  = val;
      CFG_RECV_PER_STEP: cfg_rps   = val[7:0];
      default: ;
    endcase
  endtask

  // Reprogram only with the block idle; events without commands may still be in work
  task automatic set_config(input logic [10:0] rc, input logic [9:0] own,
                            input logic [15:0] blen, input logic [7:0] rps);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(CFG_RANK_COUNT, 16'(rc));
    write_reg(CFG_OWN_RANK, 16'(own));
    write_reg(CFG_BLOCK_LEN, blen);
    write_reg(CFG_RECV_PER_STEP, 16'(rps));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Feed completions and data for the current epoch until the exchange finishes
  task automatic settle_to_start();
    wait_drained();
    while (seq_phase == PH_WAIT) begin
      add_event(make_ev($urandom_range(1) ? OP_SEND_DONE : OP_WHOLE, epoch_now));
      wait_drained();
    end
  endtask

  // One full exchange: start, copy done, then per step a send done, the final pieces
  // of that step's epoch and at times an initial piece, in random order; optionally break it
  task automatic push_collective(input bit broken);
    ev_t         seq[$];
    ev_t         step_evs[$];
    ev_t         swap;
    logic [10:0] n;
    int          rounds, x, i, j, k;
    n = eff_ranks();
    rounds = 0;
    for (x = int'(n) >> 1; x > 0; x = x >> 1) rounds++;
    if ((n & (n - 11'd1)) != 11'd0) rounds++;
    seq.push_back(make_ev(OP_START, 2'($urandom_range(3))));
    seq.push_back(make_ev(OP_COPY_DONE, 2'($urandom_range(3))));
    for (i = 1; i <= rounds; i++) begin
      step_evs.delete();
      step_evs.push_back(make_ev(OP_SEND_DONE, 2'($urandom_range(3))));
      for (j = 0; j < int'(cfg_rps); j++)
        step_evs.push_back(make_ev($urandom_range(1) ? OP_LAST : OP_WHOLE, 2'(i)));
      if ($urandom_range(3) == 0)
        step_evs.push_back(make_ev(OP_INITIAL, 2'($urandom_range(3))));
      for (j = step_evs.size() - 1; j > 0; j--) begin
        k = $urandom_range(j);
        swap = step_evs[j];
        step_evs[j] = step_evs[k];
        step_evs[k] = swap;
      end
      foreach (step_evs[j]) seq.push_back(step_evs[j]);
    end
    if (broken) begin
      k = $urandom_range(seq.size() - 1);
      if ($urandom_range(1) != 0) seq.delete(k);
      else seq.insert(k, random_event());
    end
    foreach (seq[j]) add_event(seq[j]);
  endtask

  initial begin
    int          base, next_cfg_at, cfg_idx, sel, j, burst;
    logic [10:0] rc;
    logic [9:0]  own;
    logic [15:0] blen;
    logic [7:0]  rps;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset configuration: all operations but a whole piece while idle; no data while waiting
    add_event(make_ev(OP_SEND_DONE, 2'd0));    // send done while idle
    add_event(make_ev(OP_RESERVED_LO, 2'd0));
    add_event(make_ev(OP_RESERVED_HI, 2'd3));
    add_event(make_ev(OP_INITIAL, 2'd2));      // ignored while idle
    add_event(make_ev(OP_LAST, 2'd1));         // early data, counted
    add_event(make_ev(OP_COPY_DONE, 2'd0));    // copy done without a start
    add_event(make_ev(OP_START, 2'd3));
    add_event(make_ev(OP_START, 2'd1));        // restart before the copy ends
    add_event(make_ev(OP_COPY_DONE, 2'd2));    // step opens, early data completes it
    add_event(make_ev(OP_START, 2'd0));        // wrong in the wait phase
    add_event(make_ev(OP_COPY_DONE, 2'd0));
    add_event(make_ev(OP_RESERVED_LO, 2'd1));
    add_event(make_ev(OP_INITIAL, 2'd3));      // ignored while waiting
    add_event(make_ev(OP_SEND_DONE, 2'd0));    // closes the last step: finished
    // Seven ranks from rank zero: a whole step, a split step and a split remainder step
    set_config(11'd7, 10'd0, 16'hFFFF, 8'd1);
    push_collective(1'b0);

    // Random: mostly well-formed exchanges, some broken ones and noise bursts
    base = n_pushed;
    next_cfg_at = n_pushed;
    cfg_idx = 0;
    while (n_pushed - base < RANDOM_EVENTS) begin
      if (n_pushed - base < RANDOM_EVENTS / 3) begin
        src_idle_pct = 31;
        sink_idle_pct = 62;
      end else if (n_pushed - base < 2 * RANDOM_EVENTS / 3) begin
        src_idle_pct = 62;
        sink_idle_pct = 31;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      if (n_pushed >= next_cfg_at) begin
        case (cfg_idx)
          0: set_config(11'd2047, 10'd5, 16'hFFFF, 8'd1);   // saturated rank count
          1: set_config(11'd0, 10'd1023, 16'd0, 8'd2);      // rank count zero
          2: set_config(11'd2, 10'd1, 16'd300, 8'd255);     // largest receive quota
          3: set_config(11'd7, 10'd6, 16'd1234, 8'd0);      // zero receive quota
          4: set_config(11'd1024, 10'd1023, 16'd1, 8'd3);   // largest power of two
          default: begin
            rc = ($urandom_range(3) != 0) ? 11'($urandom_range(40, 2))
                                          : 11'($urandom_range(2047));
            if ($urandom_range(4) != 0)
              own = 10'($urandom_range((rc < 11'd2) ? 0 :
                                       ((rc > MAX_RANKS) ? 1023 : int'(rc) - 1)));
            else
              own = 10'($urandom_range(1023));
            case ($urandom_range(5))
              0: blen = 16'd0;
              1: blen = 16'hFFFF;
              default: blen = 16'($urandom_range(65535));
            endcase
            rps = ($urandom_range(9) == 0) ? 8'($urandom_range(8))
                                           : 8'($urandom_range(4, 1));
            set_config(rc, own, blen, rps);
          end
        endcase
        cfg_idx++;
        next_cfg_at = n_pushed + 120;
      end
      sel = $urandom_range(99);
      if (sel < 90) begin
        settle_to_start();
        push_collective(sel >= 80);
      end else begin
        burst = $urandom_range(8, 3);
        for (j = 0; j < burst; j++) add_event(random_event());
      end
    end

    // Drain, then give a late or extra command time to show up
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/acs_pkg.sv
hw/rtl/acs_mod.sv
hw/rtl/acs_dpath.sv
hw/rtl/acs_outbuf.sv
hw/rtl/acs_ctrl.sv
hw/rtl/alltoall_collective_sequencer_unit.sv
sim/tb.sv
